### sv/integer_literal_classifier_unit_defines.svh
// assertion macros shared by the integer literal classifier modules
// depends on nothing; taken in by the modules that carry assertions
`ifndef INTEGER_LITERAL_CLASSIFIER_UNIT_DEFINES_SVH
`define INTEGER_LITERAL_CLASSIFIER_UNIT_DEFINES_SVH

// condition must never hold outside reset
`define ILC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ILC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ILC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ilc_pkg.sv
// types, codes and byte classification functions of the integer literal classifier
// depends on nothing; used by every module of the block
package ilc_pkg;

    // default saturating counter width
    localparam int COUNT_WIDTH_DEF = 16;
    // width of each counter field on the result bus
    localparam int OUT_W = 16;
    // entries of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // byte codes
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    // scan state of the word in progress
    typedef enum logic [3:0] {
        PH_EMPTY  = 4'd0,
        PH_ZERO   = 4'd1,
        PH_DEC    = 4'd2,
        PH_DECBAD = 4'd3,
        PH_OCT    = 4'd4,
        PH_OCTBAD = 4'd5,
        PH_HX0    = 4'd6,
        PH_HEX    = 4'd7,
        PH_HEXBAD = 4'd8,
        PH_BN0    = 4'd9,
        PH_BIN    = 4'd10,
        PH_BINBAD = 4'd11,
        PH_NOT    = 4'd12
    } t_phase;

    // reported word class
    typedef enum logic [3:0] {
        CLS_DEC    = 4'd0,
        CLS_OCT    = 4'd1,
        CLS_HEX    = 4'd2,
        CLS_BIN    = 4'd3,
        CLS_BADOCT = 4'd4,
        CLS_BADHEX = 4'd5,
        CLS_BADBIN = 4'd6,
        CLS_BADDEC = 4'd7,
        CLS_NOT    = 4'd8,
        CLS_NONE   = 4'd9
    } t_class;

    // command from front to back
    typedef struct packed {
        logic   emit;      // a result item goes out
        logic   has_word;  // a word finished
        logic   line_inc;  // a line is counted
        t_class cls;
    } t_cmd;

    function automatic logic f_is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic logic f_is_dig(input logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic f_is_oct(input logic [7:0] c);
        return c inside {[CH_0:CH_7]};
    endfunction

    function automatic logic f_is_hexd(input logic [7:0] c);
        return c inside {[CH_0:CH_9], [CH_LA:CH_LF], [CH_UA:CH_UF]};
    endfunction

    // next scan state for a byte that is not whitespace
    function automatic t_phase f_advance(input t_phase ph, input logic [7:0] c);
        t_phase nxt;
        nxt = ph;
        case (ph)
            PH_EMPTY: begin
                if (c == CH_0)         nxt = PH_ZERO;
                else if (f_is_dig(c))  nxt = PH_DEC;
                else                   nxt = PH_NOT;
            end
            PH_ZERO: begin
                if (f_is_oct(c))                      nxt = PH_OCT;
                else if (c inside {CH_LX, CH_UX})     nxt = PH_HX0;
                else if (c inside {CH_LB, CH_UB})     nxt = PH_BN0;
                else                                  nxt = PH_DECBAD;
            end
            PH_DEC:           nxt = f_is_dig(c) ? PH_DEC : PH_DECBAD;
            PH_OCT:           nxt = f_is_oct(c) ? PH_OCT : PH_OCTBAD;
            PH_HX0, PH_HEX:   nxt = f_is_hexd(c) ? PH_HEX : PH_HEXBAD;
            PH_BN0, PH_BIN:   nxt = (c inside {CH_0, CH_1}) ? PH_BIN : PH_BINBAD;
            default:          nxt = ph;
        endcase
        return nxt;
    endfunction

    // class of a finished word
    function automatic t_class f_phase_class(input t_phase ph);
        t_class cls;
        case (ph)
            PH_DEC:               cls = CLS_DEC;
            PH_OCT:               cls = CLS_OCT;
            PH_HEX:               cls = CLS_HEX;
            PH_BIN:               cls = CLS_BIN;
            PH_OCTBAD:            cls = CLS_BADOCT;
            PH_HX0, PH_HEXBAD:    cls = CLS_BADHEX;
            PH_BN0, PH_BINBAD:    cls = CLS_BADBIN;
            PH_ZERO, PH_DECBAD:   cls = CLS_BADDEC;
            default:              cls = CLS_NOT;
        endcase
        return cls;
    endfunction

endpackage

### sv/ilc_front.sv
// front end: splits the byte stream into words and tracks the scan state
// depends on ilc_pkg; feeds commands into ilc_queue
module ilc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_ch,
    input  logic            i_end,
    input  logic            i_q_full,
    output logic            o_ready,
    output logic            o_push,
    output ilc_pkg::t_cmd   o_cmd
);

    ilc_pkg::t_phase r_phase, n_phase;
    logic            r_line_open, n_line_open;
    logic            w_accept;
    logic            w_had;
    logic            w_nl;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_had    = (r_phase != ilc_pkg::PH_EMPTY);
    assign w_nl     = (i_ch == ilc_pkg::CH_NL);

    // decode one byte into a command and the next scan state
    always_comb begin
        n_phase         = r_phase;
        n_line_open     = r_line_open;
        o_push          = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.has_word  = w_had;
        o_cmd.line_inc  = 1'b0;
        o_cmd.cls       = ilc_pkg::f_phase_class(r_phase);
        if (w_accept) begin
            if (i_end) begin
                o_push         = 1'b1;
                o_cmd.emit     = 1'b1;
                o_cmd.line_inc = r_line_open;
                if (!w_had) begin
                    o_cmd.cls = ilc_pkg::CLS_NONE;
                end
                n_phase     = ilc_pkg::PH_EMPTY;
                n_line_open = 1'b0;
            end else if (ilc_pkg::f_is_ws(i_ch)) begin
                o_push         = w_had || w_nl;
                o_cmd.emit     = w_had;
                o_cmd.line_inc = w_nl;
                n_phase        = ilc_pkg::PH_EMPTY;
                n_line_open    = !w_nl;
            end else begin
                n_phase     = ilc_pkg::f_advance(r_phase, i_ch);
                n_line_open = 1'b1;
            end
        end
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ilc_pkg::PH_EMPTY;
            r_line_open <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_line_open <= n_line_open;
        end
    end

endmodule

### sv/ilc_queue.sv
// short command queue that decouples the front end from the counter back end
// depends on ilc_pkg and the assertion macro header
`include "integer_literal_classifier_unit_defines.svh"
module ilc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ilc_pkg::t_cmd   i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output ilc_pkg::t_cmd   o_data
);

    localparam int DEPTH = ilc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ilc_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    // pointer and fill update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `ILC_ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `ILC_ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")

endmodule

### sv/ilc_back.sv
// back end: saturating word, class and line counters and the result register
// depends on ilc_pkg and the assertion macro header; pops commands from ilc_queue
`include "integer_literal_classifier_unit_defines.svh"
module ilc_back #(
    parameter int COUNT_WIDTH = ilc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  ilc_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [3:0]                 o_class,
    output logic [7*ilc_pkg::OUT_W-1:0] o_data
);

    localparam int OW = ilc_pkg::OUT_W;

    logic [COUNT_WIDTH-1:0] r_words, n_words;
    logic [COUNT_WIDTH-1:0] r_lines, n_lines;
    logic [COUNT_WIDTH-1:0] r_cls_cnt [4];
    logic [COUNT_WIDTH-1:0] n_cls_cnt [4];
    logic [COUNT_WIDTH-1:0] w_line;
    logic [COUNT_WIDTH+OW-1:0] w_ext [7];

    logic                 r_valid;
    logic [3:0]           r_class;
    logic [7*OW-1:0]      r_data, n_data;

    assign o_pop   = i_q_valid && (!i_cmd.emit || !r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_class = r_class;
    assign o_data  = r_data;

    // counter update for the command at the queue head
    always_comb begin
        w_line  = (r_lines == '1) ? r_lines : r_lines + 1'b1;
        n_words = r_words;
        n_lines = r_lines;
        for (int k = 0; k < 4; k++) begin
            n_cls_cnt[k] = r_cls_cnt[k];
        end
        if (o_pop) begin
            if (i_cmd.has_word) begin
                n_words = (r_words == '1) ? r_words : r_words + 1'b1;
                for (int k = 0; k < 4; k++) begin
                    if (i_cmd.cls == ilc_pkg::t_class'(k)) begin
                        n_cls_cnt[k] = (r_cls_cnt[k] == '1) ? r_cls_cnt[k]
                                                            : r_cls_cnt[k] + 1'b1;
                    end
                end
            end
            if (i_cmd.line_inc) begin
                n_lines = (r_lines == '1) ? r_lines : r_lines + 1'b1;
            end
        end
    end

    // low bits of each counter for the result fields
    always_comb begin
        w_ext[0] = {{OW{1'b0}}, (i_cmd.has_word ? w_line : {COUNT_WIDTH{1'b0}})};
        w_ext[1] = {{OW{1'b0}}, n_words};
        w_ext[2] = {{OW{1'b0}}, n_cls_cnt[0]};
        w_ext[3] = {{OW{1'b0}}, n_cls_cnt[1]};
        w_ext[4] = {{OW{1'b0}}, n_cls_cnt[2]};
        w_ext[5] = {{OW{1'b0}}, n_cls_cnt[3]};
        w_ext[6] = {{OW{1'b0}}, n_lines};
        for (int k = 0; k < 7; k++) begin
            n_data[k*OW +: OW] = w_ext[k][OW-1:0];
        end
    end

    // counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= '0;
            r_lines <= '0;
            for (int k = 0; k < 4; k++) begin
                r_cls_cnt[k] <= '0;
            end
        end else begin
            r_words <= n_words;
            r_lines <= n_lines;
            for (int k = 0; k < 4; k++) begin
                r_cls_cnt[k] <= n_cls_cnt[k];
            end
        end
    end

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop && i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.emit) begin
            r_class <= i_cmd.cls;
            r_data  <= n_data;
        end
    end

    `ILC_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, o_pop && i_cmd.emit, r_valid, "result not loaded")
    `ILC_ASSERT_IMPL(a_words_mono, i_clk, i_rst_n, $past(i_rst_n), r_words >= $past(r_words), "word count fell")
    `ILC_ASSERT_IMPL(a_lines_mono, i_clk, i_rst_n, $past(i_rst_n), r_lines >= $past(r_lines), "line count fell")

endmodule

### sv/integer_literal_classifier_unit.sv
// Integer literal classifier, top level.
// Input stream: one text byte per item in s_axis tdata, tlast marks the end of
// the stream (its byte is ignored, a pending word is flushed and an open last
// line is counted). Words split at space, tab, newline, vertical tab, form feed
// and carriage return; a newline also counts a line.
// Output stream: one item for each word finished by whitespace and one for each end item.
// tuser carries the word class, tdata the line number of the word and the
// saturating word, decimal, octal, hex, binary and line counts.
// Throughput: one input item per cycle while tready is high; the front end decodes each
// accepted byte, the back end updates all counters for one command per cycle unless a result waits.
// The command for the byte that finishes a word passes through the command queue entry,
// then the result register; a result held by the receiver can stall it between them.
// Reset clears the scan state, the queue and all counters; no item is held.
// When the receiver stalls, the result register holds, the queue fills, and
// tready drops once both queue entries are taken; whitespace inside a line
// that finishes no word passes without using a queue entry.
// depends on ilc_pkg, ilc_front, ilc_queue and ilc_back
module integer_literal_classifier_unit #(
    parameter int COUNT_WIDTH = ilc_pkg::COUNT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [7:0]    i_s_axis_tdata,   // [7:0] ch
    input  logic          i_s_axis_tlast,   // end_of_input
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // [15:0] line_number, [31:16] word_count, [47:32] decimal_count,
    // [63:48] octal_count, [79:64] hex_count, [95:80] binary_count,
    // [111:96] line_count
    output logic [111:0]  o_m_axis_tdata,
    output logic [3:0]    o_m_axis_tuser    // [3:0] word_class
);

    logic          w_q_full;
    logic          w_push;
    ilc_pkg::t_cmd w_push_cmd;
    logic          w_q_valid;
    ilc_pkg::t_cmd w_head_cmd;
    logic          w_pop;

    ilc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_ch     (i_s_axis_tdata),
        .i_end    (i_s_axis_tlast),
        .i_q_full (w_q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    ilc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_head_cmd)
    );

    ilc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_cmd     (w_head_cmd),
        .o_pop     (w_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_class   (o_m_axis_tuser),
        .o_data    (o_m_axis_tdata)
    );

endmodule
